// ----- sv/qtm_pkg.sv -----
// ----------------------------------------------------------------------------
// qtm_pkg
// Types and fixed widths shared by the quaternion transform blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package qtm_pkg;

  localparam int QW   = 16;  // quaternion and scale components
  localparam int PW   = 32;  // position and result words
  localparam int SW   = 33;  // squared norm, up to 2^32
  localparam int NMW  = 34;  // signed numerator, magnitude up to 2^32
  localparam int AW   = 33;  // numerator magnitude
  localparam int MAGW = 48;  // |num| * |scale|
  localparam int NW   = 57;  // dividend 2*mag*256 + s
  localparam int DW   = 34;  // divisor 2*s
  localparam int QB   = 24;  // quotient bits
  localparam int NEL  = 9;   // matrix elements
  localparam int NAX  = 3;   // axes

  typedef struct packed {
    logic [NEL-1:0][NMW-1:0] num;
    logic [SW-1:0]           s;
    logic [NAX-1:0][QW-1:0]  scale;
    logic [NAX-1:0][PW-1:0]  pos;
  } mid_t;

  typedef struct packed {
    logic [NEL-1:0]         neg;
    logic [NAX-1:0][PW-1:0] pos;
  } side_t;

  typedef struct packed {
    logic [NEL-1:0][PW-1:0] elem;
    logic [NAX-1:0][PW-1:0] trans;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/qtm_fifo.sv -----
// ----------------------------------------------------------------------------
// qtm_fifo
// Small register queue with show-ahead read, used between pipeline parts.
// ----------------------------------------------------------------------------
`default_nettype none

module qtm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wptr, rptr;
  logic [CNTW-1:0]  count;
  logic             do_wr, do_rd;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTRW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTRW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH)) else $error("fifo count out of range");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(full && empty)) else $error("fifo full and empty at once");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    (!do_wr && !do_rd) |=> $stable(count)) else $error("fifo count moved");

endmodule

`default_nettype wire

// ----- sv/qtm_front.sv -----
// ----------------------------------------------------------------------------
// qtm_front
// Takes items, forms quaternion products, norm and the nine numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module qtm_front (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     en,
  input  wire logic                                     take,
  input  wire logic [3:0][qtm_pkg::QW-1:0]              quat,  // x y z w
  input  wire logic [qtm_pkg::NAX-1:0][qtm_pkg::QW-1:0] scale,
  input  wire logic [qtm_pkg::NAX-1:0][qtm_pkg::PW-1:0] pos,
  output logic                                          out_valid,
  output qtm_pkg::mid_t                                 out_item
);

  import qtm_pkg::*;

  logic signed [QW-1:0] qx, qy, qz, qw;
  assign qx = $signed(quat[0]);
  assign qy = $signed(quat[1]);
  assign qz = $signed(quat[2]);
  assign qw = $signed(quat[3]);

  // stage 0: pairwise products
  logic                   v0;
  logic signed [31:0]     pxx, pyy, pzz, pww, pxy, pxz, pyz, pwx, pwy, pwz;
  logic [NAX-1:0][QW-1:0] scale0;
  logic [NAX-1:0][PW-1:0] pos0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx    <= qx * qx;
      pyy    <= qy * qy;
      pzz    <= qz * qz;
      pww    <= qw * qw;
      pxy    <= qx * qy;
      pxz    <= qx * qz;
      pyz    <= qy * qz;
      pwx    <= qw * qx;
      pwy    <= qw * qy;
      pwz    <= qw * qz;
      scale0 <= scale;
      pos0   <= pos;
    end
  end

  // stage 1: norm and numerators; a zero quaternion takes s = 1 (identity)
  logic [SW-1:0]         s_raw, s_eff;
  logic signed [NMW-1:0] s_sg;
  logic [NEL-1:0][NMW-1:0] num;

  always_comb begin
    s_raw = {1'b0, pxx} + {1'b0, pyy} + {1'b0, pzz} + {1'b0, pww};
    s_eff = (s_raw == '0) ? SW'(1) : s_raw;
    s_sg  = $signed({1'b0, s_eff});
    num[0] = s_sg - ((NMW'(pyy) + NMW'(pzz)) <<< 1);
    num[1] = (NMW'(pxy) - NMW'(pwz)) <<< 1;
    num[2] = (NMW'(pxz) + NMW'(pwy)) <<< 1;
    num[3] = (NMW'(pxy) + NMW'(pwz)) <<< 1;
    num[4] = s_sg - ((NMW'(pxx) + NMW'(pzz)) <<< 1);
    num[5] = (NMW'(pyz) - NMW'(pwx)) <<< 1;
    num[6] = (NMW'(pxz) - NMW'(pwy)) <<< 1;
    num[7] = (NMW'(pyz) + NMW'(pwx)) <<< 1;
    num[8] = s_sg - ((NMW'(pxx) + NMW'(pyy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.num   <= num;
      out_item.s     <= s_eff;
      out_item.scale <= scale0;
      out_item.pos   <= pos0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/qtm_div.sv -----
// ----------------------------------------------------------------------------
// qtm_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qtm_div (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic [qtm_pkg::DW-1:0]                  rem_in,
  input  wire logic [qtm_pkg::QB-1:0]                  lo_in,
  input  wire logic [qtm_pkg::QB-1:0][qtm_pkg::DW-1:0] dvs,  // divisor at each stage
  output logic      [qtm_pkg::QB-1:0]                  quo
);

  import qtm_pkg::*;

  logic [DW-1:0] rem [QB+1];
  logic [QB-1:0] lo  [QB+1];

  assign rem[0] = rem_in;
  assign lo[0]  = lo_in;

  // low word shifts out dividend bits and shifts in quotient bits
  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [DW:0] t, diff;
    logic        ge;
    always_comb begin
      t    = {rem[j], lo[j][QB-1]};
      diff = t - {1'b0, dvs[j]};
      ge   = (t >= {1'b0, dvs[j]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        lo[j+1]  <= {lo[j][QB-2:0], ge};
      end
    end
  end

  assign quo = lo[QB];

endmodule

`default_nettype wire

// ----- sv/qtm_back.sv -----
// ----------------------------------------------------------------------------
// qtm_back
// Scales numerators, divides by the norm with rounding, applies signs.
// ----------------------------------------------------------------------------
`default_nettype none

module qtm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire qtm_pkg::mid_t in_item,
  output logic               in_take,
  output logic               out_valid,
  output qtm_pkg::res_t      out_item
);

  import qtm_pkg::*;

  // stage 0 magnitudes, stage 1 dividend, QB divider stages, final sign stage
  localparam int LAT = QB + 3;

  logic [LAT-1:0] v;
  side_t          side [LAT-1];

  assign in_take = en && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-2:0], in_valid};
    end
  end

  // stage 0
  logic [NEL-1:0][MAGW-1:0] mag_c, mag0;
  logic [NEL-1:0]           neg_c;
  logic [SW-1:0]            s0;

  always_comb begin
    for (int i = 0; i < NEL; i++) begin
      logic signed [NMW-1:0] nm;
      logic signed [QW:0]    sc;
      logic [NMW-1:0]        an;
      logic [QW:0]           as;
      nm = $signed(in_item.num[i]);
      sc = $signed({in_item.scale[i/3][QW-1], in_item.scale[i/3]});
      an = (nm < 0) ? NMW'(-nm) : NMW'(nm);
      as = (sc < 0) ? (QW+1)'(-sc) : (QW+1)'(sc);
      mag_c[i] = MAGW'(an[AW-1:0]) * MAGW'(as[QW-1:0]);
      neg_c[i] = (nm < 0) != (sc < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0        <= mag_c;
      s0          <= in_item.s;
      side[0].neg <= neg_c;
      side[0].pos <= in_item.pos;
    end
  end

  // stage 1: dividend 2*mag*256 + s over divisor 2*s
  logic [NEL-1:0][NW-1:0]   dvd;
  logic [QB-1:0][DW-1:0]    dpipe;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NEL; i++) begin
        dvd[i] <= {mag0[i], 9'b0} + NW'(s0);
      end
      // divisor follows its item down the divider stages
      dpipe <= {dpipe[QB-2:0], DW'({s0, 1'b0})};
    end
  end

  for (genvar k = 1; k < LAT - 1; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side[k-1];
      end
    end
  end

  logic [NEL-1:0][QB-1:0] quo;

  for (genvar i = 0; i < NEL; i++) begin : g_lane
    qtm_div u_div (
      .clk    (clk),
      .en     (en),
      .rem_in (DW'(dvd[i][NW-1:QB])),
      .lo_in  (dvd[i][QB-1:0]),
      .dvs    (dpipe),
      .quo    (quo[i])
    );
  end

  // final stage: signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NEL; i++) begin
        out_item.elem[i] <= side[LAT-2].neg[i] ? (PW'(0) - PW'(quo[i])) : PW'(quo[i]);
      end
      out_item.trans <= side[LAT-2].pos;
    end
  end

  assign out_valid = v[LAT-1];

endmodule

`default_nettype wire

// ----- sv/quaternion_to_transform_matrix.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_transform_matrix
// Affine transform from position, quaternion and per-axis scale.
// ----------------------------------------------------------------------------
// Takes one item per cycle while full is low and returns one result per cycle
// while the results are popped, bit exact, with ties of the normalizing division
// rounded away from zero. An item passes 2 front stages, the middle queue, 27
// back stages (a magnitude multiply stage, a dividend stage, a 24 stage
// restoring divider, a sign stage) and the result queue. Full asserts only
// while the middle queue is full; both queues let the front and back parts
// stall independently. A zero quaternion gives the identity rotation.
`default_nettype none

module quaternion_to_transform_matrix #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] scale_x,
  input  wire logic signed [15:0] scale_y,
  input  wire logic signed [15:0] scale_z,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      x_axis_0,
  output logic signed [31:0]      x_axis_1,
  output logic signed [31:0]      x_axis_2,
  output logic signed [31:0]      y_axis_0,
  output logic signed [31:0]      y_axis_1,
  output logic signed [31:0]      y_axis_2,
  output logic signed [31:0]      z_axis_0,
  output logic signed [31:0]      z_axis_1,
  output logic signed [31:0]      z_axis_2,
  output logic signed [31:0]      trans_x,
  output logic signed [31:0]      trans_y,
  output logic signed [31:0]      trans_z
);

  import qtm_pkg::*;

  logic  mq_full, mq_empty, mq_push, f_en, f_valid;
  mid_t  f_item, mq_item;
  logic  oq_full, oq_push, b_en, b_take, b_valid;
  res_t  b_item, oq_item;

  assign f_en    = !mq_full;
  assign full    = !f_en;
  assign mq_push = f_en && f_valid;

  qtm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (f_en),
    .take      (push && f_en),
    .quat      ({quat_w, quat_z, quat_y, quat_x}),
    .scale     ({scale_z, scale_y, scale_x}),
    .pos       ({pos_z, pos_y, pos_x}),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  qtm_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_midq (
    .clk   (clk),
    .rst   (rst),
    .wr    (mq_push),
    .wdata (f_item),
    .rd    (b_take),
    .rdata (mq_item),
    .full  (mq_full),
    .empty (mq_empty)
  );

  assign b_en    = !oq_full;
  assign oq_push = b_en && b_valid;

  qtm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (b_en),
    .in_valid  (!mq_empty),
    .in_item   (mq_item),
    .in_take   (b_take),
    .out_valid (b_valid),
    .out_item  (b_item)
  );

  qtm_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (oq_push),
    .wdata (b_item),
    .rd    (pop),
    .rdata (oq_item),
    .full  (oq_full),
    .empty (empty)
  );

  assign x_axis_0 = $signed(oq_item.elem[0]);
  assign x_axis_1 = $signed(oq_item.elem[1]);
  assign x_axis_2 = $signed(oq_item.elem[2]);
  assign y_axis_0 = $signed(oq_item.elem[3]);
  assign y_axis_1 = $signed(oq_item.elem[4]);
  assign y_axis_2 = $signed(oq_item.elem[5]);
  assign z_axis_0 = $signed(oq_item.elem[6]);
  assign z_axis_1 = $signed(oq_item.elem[7]);
  assign z_axis_2 = $signed(oq_item.elem[8]);
  assign trans_x  = $signed(oq_item.trans[0]);
  assign trans_y  = $signed(oq_item.trans[1]);
  assign trans_z  = $signed(oq_item.trans[2]);

  a_oq_no_overrun: assert property (@(posedge clk) disable iff (rst)
    oq_full |-> !oq_push) else $error("result queue overrun");

  a_mq_no_overrun: assert property (@(posedge clk) disable iff (rst)
    mq_full |-> !mq_push) else $error("middle queue overrun");

  a_back_take: assert property (@(posedge clk) disable iff (rst)
    b_take |-> !mq_empty && !oq_full) else $error("back took item it cannot hold");

endmodule

`default_nettype wire
